>>> hdl/two_link_arm_jog_inverse_kinematics_macros.svh
// Assertion macros used by the arm jog inverse kinematics controller
`ifndef TWO_LINK_ARM_JOG_INVERSE_KINEMATICS_MACROS_SVH
`define TWO_LINK_ARM_JOG_INVERSE_KINEMATICS_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define TJIK_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define TJIK_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/tjik_pkg.sv
// Types, codes, constants and the arctangent table of the arm jog block
`default_nettype none
package tjik_pkg;

    localparam int FRAC_BITS_DEF  = 28;
    localparam int CORDIC_ITER_DEF = 28;

    localparam logic [1:0] CFG_DEADBAND   = 2'd0;
    localparam logic [1:0] CFG_JOG_STEP   = 2'd1;
    localparam logic [1:0] CFG_UPPER_LINK = 2'd2;
    localparam logic [1:0] CFG_LOWER_LINK = 2'd3;

    typedef struct packed {
        logic signed [15:0] stick_x;
        logic signed [15:0] stick_y;
        logic signed [15:0] stick_base;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] base_drive;
        logic signed [31:0] shoulder_angle;
        logic signed [31:0] elbow_angle;
        logic               move_rejected;
        logic               cosine_clamped;
    } out_item_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_MNX, OP_MNY, OP_MRE, OP_REJ, OP_MX, OP_MY,
        OP_ML1, OP_ML2, OP_MD, OP_NUM, OP_DSET, OP_DIV, OP_MCM, OP_SSET,
        OP_SQRT, OP_CL2, OP_CRUN, OP_MN, OP_MDC, OP_DSUM, OP_CLT, OP_CLQ,
        OP_OUT
    } op_t;

    typedef enum logic [4:0] {
        S_IDLE, S_MNX, S_MNY, S_MRE, S_REJ, S_MX, S_MY, S_ML1, S_ML2, S_MD,
        S_NUM, S_DSET, S_DIV, S_MCM, S_SSET, S_SQRT, S_CL2, S_RUN2, S_MN,
        S_MDC, S_DSUM, S_CLT, S_RUNT, S_CLQ, S_RUNQ, S_OUT
    } state_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic sqrt_done;
        logic cordic_done;
    } status_t;

    function automatic logic [31:0] atan_entry(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd3373259426;
            5'd1:  v = 32'd1991351318;
            5'd2:  v = 32'd1052175346;
            5'd3:  v = 32'd534100635;
            5'd4:  v = 32'd268086748;
            5'd5:  v = 32'd134174063;
            5'd6:  v = 32'd67103403;
            5'd7:  v = 32'd33553749;
            5'd8:  v = 32'd16777131;
            5'd9:  v = 32'd8388597;
            5'd10: v = 32'd4194303;
            5'd11: v = 32'd2097152;
            5'd12: v = 32'd1048576;
            5'd13: v = 32'd524288;
            5'd14: v = 32'd262144;
            5'd15: v = 32'd131072;
            5'd16: v = 32'd65536;
            5'd17: v = 32'd32768;
            5'd18: v = 32'd16384;
            5'd19: v = 32'd8192;
            5'd20: v = 32'd4096;
            5'd21: v = 32'd2048;
            5'd22: v = 32'd1024;
            5'd23: v = 32'd512;
            5'd24: v = 32'd256;
            5'd25: v = 32'd128;
            5'd26: v = 32'd64;
            5'd27: v = 32'd32;
            5'd28: v = 32'd16;
            5'd29: v = 32'd8;
            5'd30: v = 32'd4;
            default: v = 32'd2;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

>>> hdl/two_link_arm_jog_inverse_kinematics.sv
// Each of the three CORDIC runs first normalizes its vector, then rotates it.
// A saturated cosine skips the divide.
// Throughput: one item at a time; the serial divider, square root and shared CORDIC set it.
// The next input is taken once the result sits in the output register.
// Reset clears the tip to (0.5, 0.5) and loads the default deadband, jog step and links.
`default_nettype none
module two_link_arm_jog_inverse_kinematics #(
    parameter int FRAC_BITS         = tjik_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_ITERATIONS = tjik_pkg::CORDIC_ITER_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                stick_valid,
    output logic                     stick_stall,
    input  wire tjik_pkg::in_item_t  stick_data,
    output logic                     joint_valid,
    input  wire logic                joint_stall,
    output tjik_pkg::out_item_t      joint_data,
    input  wire logic                cfg_write,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [28:0]         cfg_data
);
    import tjik_pkg::*;

    cmd_t    cmd;
    status_t status;

    tjik_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .stick_valid (stick_valid),
        .stick_stall (stick_stall),
        .joint_valid (joint_valid),
        .joint_stall (joint_stall),
        .cmd         (cmd),
        .status      (status)
    );

    tjik_datapath #(
        .FRAC_BITS         (FRAC_BITS),
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .stick_data (stick_data),
        .joint_data (joint_data),
        .cmd        (cmd),
        .status     (status)
    );

endmodule
`default_nettype wire

>>> hdl/tjik_datapath.sv
// Datapath: config, tip state, multiplier, divider, square root and CORDIC
`default_nettype none
module tjik_datapath #(
    parameter int FRAC_BITS         = 28,
    parameter int CORDIC_ITERATIONS = 28
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_write,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [28:0]         cfg_data,
    input  wire tjik_pkg::in_item_t  stick_data,
    output tjik_pkg::out_item_t      joint_data,
    input  wire tjik_pkg::cmd_t      cmd,
    output tjik_pkg::status_t        status
);
    import tjik_pkg::*;

    localparam int F   = FRAC_BITS;
    localparam int CW  = 36;
    localparam int DCW = $clog2(FRAC_BITS + 1);
    localparam int ICW = $clog2(CORDIC_ITERATIONS + 1);
    localparam logic [63:0] ONE    = 64'd1 << F;
    localparam logic [63:0] ONE_SQ = 64'd1 << (2 * F);
    localparam logic [32:0] RND    = 33'd1 << (31 - F);
    localparam int SH = 32 - F;
    localparam logic signed [CW-1:0] PI_Q =
        CW'((35'd13493037705 + 35'(RND)) >> SH);
    localparam logic signed [CW-1:0] PI2_Q =
        CW'((35'd6746518852 + 35'(RND)) >> SH);
    localparam logic signed [CW-1:0] NRM = CW'(64'd1 << 30);
    localparam logic signed [31:0] TIP_RST = 32'(64'd1 << (F - 1));
    localparam logic [19:0] JOG_RST  = 20'(((64'd2 << F) + 64'd5000) / 64'd10000);
    localparam logic [28:0] LINK_RST = 29'(((64'd58 << F) + 64'd50) / 64'd100);
    localparam logic signed [33:0] LIM = 34'sd2147483648;

    function automatic logic signed [16:0] dead(input logic signed [15:0] a,
                                                input logic [14:0] db);
        logic signed [16:0] v;
        logic        [16:0] m;
        v = 17'(a);
        m = v[16] ? 17'(-v) : 17'(v);
        return (m <= {2'b00, db}) ? 17'sd0 : v;
    endfunction

    logic [14:0] deadband_reg;
    logic [19:0] jog_reg;
    logic [28:0] l1_reg, l2_reg;
    logic signed [31:0] tip_x_reg, tip_y_reg;

    logic signed [15:0] base_reg;
    logic signed [33:0] nx_reg, ny_reg;
    logic rej_reg, clamp_reg;
    logic [63:0] prod_reg, acc_reg, lsum_reg, den_reg, rem_reg;
    logic signed [63:0] num_reg;
    logic [F:0] quo_reg;
    logic [DCW-1:0] dcnt_reg;
    logic [63:0] sqv_reg, sqres_reg, sqbit_reg;
    logic signed [F+1:0] c_reg;
    logic [F:0] s_reg;
    logic signed [CW-1:0] cx_reg, cy_reg, cz_reg, q2_reg, t_reg;
    logic [ICW-1:0] ci_reg;
    logic citer_reg, czero_reg;
    logic signed [31:0] n_reg, d_reg;
    out_item_t joint_reg;

    logic signed [16:0] ax, ay, ab;
    logic signed [37:0] px, py, tx, ty;
    logic signed [32:0] ma, mb;
    logic signed [65:0] mp;
    logic rej_now;
    logic [63:0] mag;
    logic [63:0] rem2, sqt;
    logic signed [CW-1:0] ld_x, ld_y, sx, sy, zst;
    logic cdone, cnorm;
    logic signed [63:0] ptr;

    always_comb
    begin
        ax = dead(stick_data.stick_x, deadband_reg);
        ay = dead(stick_data.stick_y, deadband_reg);
        ab = dead(stick_data.stick_base, deadband_reg);
        px = 38'(ax) * $signed({18'd0, jog_reg});
        py = 38'(ay) * $signed({18'd0, jog_reg});
        tx = px[37] ? -((-px) >>> 15) : (px >>> 15);
        ty = py[37] ? -((-py) >>> 15) : (py >>> 15);
    end

    always_comb
    begin
        ma = '0;
        mb = '0;
        case (cmd.op)
            OP_MNX: begin ma = $signed(nx_reg[32:0]); mb = ma; end
            OP_MNY: begin ma = $signed(ny_reg[32:0]); mb = ma; end
            OP_MRE:
            begin
                ma = $signed({3'b000, {1'b0, l1_reg} + {1'b0, l2_reg}});
                mb = ma;
            end
            OP_MX:  begin ma = 33'(tip_x_reg); mb = ma; end
            OP_MY:  begin ma = 33'(tip_y_reg); mb = ma; end
            OP_ML1: begin ma = $signed({4'd0, l1_reg}); mb = ma; end
            OP_ML2: begin ma = $signed({4'd0, l2_reg}); mb = ma; end
            OP_MD:  begin ma = $signed({4'd0, l1_reg}); mb = $signed({4'd0, l2_reg}); end
            OP_MCM: begin ma = $signed(33'(quo_reg)); mb = ma; end
            OP_MN:  begin ma = $signed({4'd0, l2_reg}); mb = $signed(33'(s_reg)); end
            OP_MDC: begin ma = $signed({4'd0, l2_reg}); mb = 33'(c_reg); end
            default: begin ma = '0; mb = '0; end
        endcase
        mp = 66'(ma) * 66'(mb);
    end

    always_comb
    begin
        rej_now = (nx_reg >= LIM) || (nx_reg <= -LIM) || (ny_reg >= LIM) ||
                  (ny_reg <= -LIM) || (acc_reg > prod_reg);
        mag  = num_reg[63] ? 64'(-num_reg) : 64'(num_reg);
        rem2 = rem_reg << 1;
        sqt  = sqres_reg + sqbit_reg;
        ptr  = $signed(prod_reg);
        ptr  = ptr[63] ? -((-ptr) >>> F) : (ptr >>> F);
    end

    always_comb
    begin
        case (cmd.op)
            OP_CL2:
            begin
                ld_y = CW'($signed({1'b0, sqres_reg[F:0]}));
                ld_x = CW'(c_reg);
            end
            OP_CLT:
            begin
                ld_y = d_reg[31] ? -CW'(n_reg) : CW'(n_reg);
                ld_x = d_reg[31] ? -CW'(d_reg) : CW'(d_reg);
            end
            default:
            begin
                ld_y = CW'(tip_y_reg);
                ld_x = CW'(tip_x_reg);
            end
        endcase
        sx    = cx_reg >>> ci_reg;
        sy    = cy_reg >>> ci_reg;
        zst   = CW'((33'(atan_entry(ci_reg[4:0])) + RND) >> SH);
        cdone = czero_reg || (citer_reg && (ci_reg == ICW'(CORDIC_ITERATIONS)));
        cnorm = !citer_reg && (cx_reg < NRM) && (cx_reg > -NRM) &&
                (cy_reg < NRM) && (cy_reg > -NRM);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadband_reg <= 15'd1638;
            jog_reg      <= JOG_RST;
            l1_reg       <= LINK_RST;
            l2_reg       <= LINK_RST;
            tip_x_reg    <= TIP_RST;
            tip_y_reg    <= TIP_RST;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_DEADBAND:   deadband_reg <= cfg_data[14:0];
                    CFG_JOG_STEP:   jog_reg      <= cfg_data[19:0];
                    CFG_UPPER_LINK: l1_reg       <= cfg_data;
                    CFG_LOWER_LINK: l2_reg       <= cfg_data;
                    default:        deadband_reg <= deadband_reg;
                endcase
            end
            if (cmd.op == OP_REJ && !rej_now)
            begin
                tip_x_reg <= nx_reg[31:0];
                tip_y_reg <= ny_reg[31:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mp[63:0];
        case (cmd.op)
            OP_LOAD:
            begin
                base_reg <= ab[15:0];
                nx_reg   <= 34'(tip_x_reg) + 34'(tx);
                ny_reg   <= 34'(tip_y_reg) + 34'(ty);
            end
            OP_MNY, OP_MY: acc_reg <= prod_reg;
            OP_MRE, OP_ML1: acc_reg <= acc_reg + prod_reg;
            OP_REJ: rej_reg <= rej_now;
            OP_ML2: lsum_reg <= prod_reg;
            OP_MD:  lsum_reg <= lsum_reg + prod_reg;
            OP_NUM:
            begin
                num_reg <= $signed(acc_reg - lsum_reg);
                den_reg <= prod_reg << 1;
            end
            OP_DSET:
            begin
                if (den_reg == 64'd0)
                begin
                    clamp_reg <= (num_reg != 64'sd0);
                    quo_reg   <= (num_reg != 64'sd0) ? ONE[F:0] : '0;
                    dcnt_reg  <= DCW'(F);
                end
                else if (mag >= den_reg)
                begin
                    clamp_reg <= (mag > den_reg);
                    quo_reg   <= ONE[F:0];
                    dcnt_reg  <= DCW'(F);
                end
                else
                begin
                    clamp_reg <= 1'b0;
                    rem_reg   <= mag;
                    quo_reg   <= '0;
                    dcnt_reg  <= '0;
                end
            end
            OP_DIV:
            begin
                if (dcnt_reg != DCW'(F))
                begin
                    if (rem2 >= den_reg)
                    begin
                        rem_reg <= rem2 - den_reg;
                        quo_reg <= {quo_reg[F-1:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem2;
                        quo_reg <= {quo_reg[F-1:0], 1'b0};
                    end
                    dcnt_reg <= dcnt_reg + 1'b1;
                end
            end
            OP_MCM:
            begin
                c_reg <= num_reg[63] ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
            end
            OP_SSET:
            begin
                sqv_reg   <= ONE_SQ - prod_reg;
                sqres_reg <= '0;
                sqbit_reg <= 64'd1 << 62;
            end
            OP_SQRT:
            begin
                if (sqbit_reg != 64'd0)
                begin
                    if (sqv_reg >= sqt)
                    begin
                        sqv_reg   <= sqv_reg - sqt;
                        sqres_reg <= (sqres_reg >> 1) + sqbit_reg;
                    end
                    else
                    begin
                        sqres_reg <= sqres_reg >> 1;
                    end
                    sqbit_reg <= sqbit_reg >> 2;
                end
            end
            OP_CL2: s_reg <= sqres_reg[F:0];
            OP_CRUN:
            begin
                if (!cdone)
                begin
                    if (cnorm)
                    begin
                        cx_reg <= cx_reg <<< 1;
                        cy_reg <= cy_reg <<< 1;
                    end
                    else
                    begin
                        if (cy_reg > 0)
                        begin
                            cx_reg <= cx_reg + sy;
                            cy_reg <= cy_reg - sx;
                            cz_reg <= cz_reg + zst;
                        end
                        else
                        begin
                            cx_reg <= cx_reg - sy;
                            cy_reg <= cy_reg + sx;
                            cz_reg <= cz_reg - zst;
                        end
                        citer_reg <= 1'b1;
                        ci_reg    <= ci_reg + 1'b1;
                    end
                end
            end
            OP_MN:  q2_reg <= cz_reg;
            OP_MDC: n_reg <= 32'($signed(prod_reg) >>> F);
            OP_DSUM: d_reg <= $signed({3'b000, l1_reg}) + 32'(ptr);
            OP_CLQ:
            begin
                if (d_reg == 32'sd0)
                    t_reg <= (n_reg != 32'sd0) ? PI2_Q : '0;
                else
                    t_reg <= cz_reg;
            end
            OP_OUT:
            begin
                joint_reg.base_drive     <= base_reg;
                joint_reg.shoulder_angle <= 32'(cz_reg - t_reg);
                joint_reg.elbow_angle    <= 32'(q2_reg);
                joint_reg.move_rejected  <= rej_reg;
                joint_reg.cosine_clamped <= clamp_reg;
            end
            default: acc_reg <= acc_reg;
        endcase
        if (cmd.op == OP_CL2 || cmd.op == OP_CLT || cmd.op == OP_CLQ)
        begin
            czero_reg <= (ld_x == '0) && (ld_y == '0);
            citer_reg <= 1'b0;
            ci_reg    <= '0;
            if (ld_x < 0)
            begin
                cx_reg <= -ld_x;
                cy_reg <= -ld_y;
                cz_reg <= (ld_y >= 0) ? PI_Q : -PI_Q;
            end
            else
            begin
                cx_reg <= ld_x;
                cy_reg <= ld_y;
                cz_reg <= '0;
            end
        end
    end

    assign joint_data         = joint_reg;
    assign status.div_done    = (dcnt_reg == DCW'(F));
    assign status.sqrt_done   = (sqbit_reg == 64'd0);
    assign status.cordic_done = cdone;

endmodule
`default_nettype wire

>>> hdl/tjik_ctrl.sv
// Controller: sequences the datapath operations and owns the handshakes
`default_nettype none
`include "two_link_arm_jog_inverse_kinematics_macros.svh"
module tjik_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               stick_valid,
    output logic                    stick_stall,
    output logic                    joint_valid,
    input  wire logic               joint_stall,
    output tjik_pkg::cmd_t          cmd,
    input  wire tjik_pkg::status_t  status
);
    import tjik_pkg::*;

    state_t state_reg, state_next;
    logic   joint_valid_reg, joint_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            joint_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            joint_valid_reg <= joint_valid_next;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        cmd.op           = OP_NONE;
        joint_valid_next = joint_valid_reg && joint_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (stick_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_MNX;
                end
            end
            S_MNX:  begin cmd.op = OP_MNX;  state_next = S_MNY; end
            S_MNY:  begin cmd.op = OP_MNY;  state_next = S_MRE; end
            S_MRE:  begin cmd.op = OP_MRE;  state_next = S_REJ; end
            S_REJ:  begin cmd.op = OP_REJ;  state_next = S_MX;  end
            S_MX:   begin cmd.op = OP_MX;   state_next = S_MY;  end
            S_MY:   begin cmd.op = OP_MY;   state_next = S_ML1; end
            S_ML1:  begin cmd.op = OP_ML1;  state_next = S_ML2; end
            S_ML2:  begin cmd.op = OP_ML2;  state_next = S_MD;  end
            S_MD:   begin cmd.op = OP_MD;   state_next = S_NUM; end
            S_NUM:  begin cmd.op = OP_NUM;  state_next = S_DSET; end
            S_DSET: begin cmd.op = OP_DSET; state_next = S_DIV; end
            S_DIV:
            begin
                cmd.op = OP_DIV;
                if (status.div_done)
                    state_next = S_MCM;
            end
            S_MCM:  begin cmd.op = OP_MCM;  state_next = S_SSET; end
            S_SSET: begin cmd.op = OP_SSET; state_next = S_SQRT; end
            S_SQRT:
            begin
                cmd.op = OP_SQRT;
                if (status.sqrt_done)
                    state_next = S_CL2;
            end
            S_CL2:  begin cmd.op = OP_CL2;  state_next = S_RUN2; end
            S_RUN2:
            begin
                cmd.op = OP_CRUN;
                if (status.cordic_done)
                    state_next = S_MN;
            end
            S_MN:   begin cmd.op = OP_MN;   state_next = S_MDC; end
            S_MDC:  begin cmd.op = OP_MDC;  state_next = S_DSUM; end
            S_DSUM: begin cmd.op = OP_DSUM; state_next = S_CLT; end
            S_CLT:  begin cmd.op = OP_CLT;  state_next = S_RUNT; end
            S_RUNT:
            begin
                cmd.op = OP_CRUN;
                if (status.cordic_done)
                    state_next = S_CLQ;
            end
            S_CLQ:  begin cmd.op = OP_CLQ;  state_next = S_RUNQ; end
            S_RUNQ:
            begin
                cmd.op = OP_CRUN;
                if (status.cordic_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!joint_valid_reg || !joint_stall)
                begin
                    cmd.op           = OP_OUT;
                    joint_valid_next = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign stick_stall = (state_reg != S_IDLE);
    assign joint_valid = joint_valid_reg;

    `TJIK_ASSERT_IMP(a_out_free, cmd.op == OP_OUT, !joint_valid || !joint_stall, "output overwritten")
    `TJIK_ASSERT_NXT(a_out_valid, cmd.op == OP_OUT, joint_valid, "result not presented")
    `TJIK_ASSERT_NXT(a_busy_after_take, stick_valid && !stick_stall, stick_stall, "second transfer taken")
    `TJIK_ASSERT_IMP(a_load_idle, cmd.op == OP_LOAD, stick_valid && !stick_stall, "load without transfer")

endmodule
`default_nettype wire

>>> tb/sv/tjik_joint_checker.sv
// Joint solution checker: predicts the arm jog result of each stick transfer and compares it
module tjik_joint_checker
    import tjik_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        stick_valid,
    input  wire logic        stick_stall,
    input  wire in_item_t    stick_data,
    input  wire logic        joint_valid,
    input  wire logic        joint_stall,
    input  wire out_item_t   joint_data,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [28:0] cfg_data,
    output int               errors,
    output int               pending,
    output int               solved,
    output int               refused,
    output int               clamps
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int       FB = 28;
    localparam int       ITER = 28;
    localparam longint   ONE = longint'(1) << FB;
    localparam longint unsigned PI_Q32 = 64'd13493037705;
    localparam longint unsigned HALF_PI_Q32 = 64'd6746518852;

    longint unsigned atan_q32 [28] = '{
        64'd3373259426, 64'd1991351318, 64'd1052175346, 64'd534100635,
        64'd268086748, 64'd134174063, 64'd67103403, 64'd33553749,
        64'd16777131, 64'd8388597, 64'd4194303, 64'd2097152,
        64'd1048576, 64'd524288, 64'd262144, 64'd131072,
        64'd65536, 64'd32768, 64'd16384, 64'd8192,
        64'd4096, 64'd2048, 64'd1024, 64'd512,
        64'd256, 64'd128, 64'd64, 64'd32
    };

    longint    deadband;
    longint    jog_step;
    longint    upper_link;
    longint    lower_link;
    longint    tip_x;
    longint    tip_y;
    out_item_t predicted_joints [$];

    function automatic longint q32_to_q(longint unsigned v);
        return longint'((v + (64'd1 << (31 - FB))) >> (32 - FB));
    endfunction

    function automatic longint magn(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint trunc_shift(longint v, int s);
        return (v >= 0) ? (v >>> s) : -((-v) >>> s);
    endfunction

    function automatic longint unsigned int_root(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint arc_tangent(longint y, longint x);
        longint z;
        longint sx;
        longint sy;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            z = (y >= 0) ? q32_to_q(PI_Q32) : -q32_to_q(PI_Q32);
            x = -x;
            y = -y;
        end
        while (magn(x) < (longint'(1) << 30) && magn(y) < (longint'(1) << 30))
        begin
            x = x * 2;
            y = y * 2;
        end
        for (int i = 0; i < ITER; i++)
        begin
            sx = x >>> i;
            sy = y >>> i;
            if (y > 0)
            begin
                x = x + sy;
                y = y - sx;
                z = z + q32_to_q(atan_q32[i]);
            end
            else
            begin
                x = x - sy;
                y = y + sx;
                z = z - q32_to_q(atan_q32[i]);
            end
        end
        return z;
    endfunction

    function automatic out_item_t solve_joints(in_item_t stick);
        out_item_t r;
        longint ax, ay, ab, nx, ny, reach, num, den, cm, c, s, n, d, t, q1, q2;
        longint rem, quo;
        logic rej, clamped;
        ax = stick.stick_x;
        ay = stick.stick_y;
        ab = stick.stick_base;
        clamped = 1'b0;
        if (magn(ax) <= deadband) ax = 0;
        if (magn(ay) <= deadband) ay = 0;
        if (magn(ab) <= deadband) ab = 0;
        nx = tip_x + trunc_shift(ax * jog_step, 15);
        ny = tip_y + trunc_shift(ay * jog_step, 15);
        reach = (upper_link + lower_link) * (upper_link + lower_link);
        if (magn(nx) >= (longint'(1) << 31) || magn(ny) >= (longint'(1) << 31))
            rej = 1'b1;
        else
            rej = (nx * nx + ny * ny) > reach;
        if (!rej)
        begin
            tip_x = nx;
            tip_y = ny;
        end
        num = tip_x * tip_x + tip_y * tip_y
            - (upper_link * upper_link + lower_link * lower_link);
        den = 2 * upper_link * lower_link;
        if (den == 0)
        begin
            clamped = (num != 0);
            cm = (num != 0) ? ONE : 0;
        end
        else if (magn(num) > den)
        begin
            clamped = 1'b1;
            cm = ONE;
        end
        else if (magn(num) == den)
            cm = ONE;
        else
        begin
            rem = magn(num);
            quo = 0;
            for (int i = 0; i < FB; i++)
            begin
                rem = rem << 1;
                quo = quo << 1;
                if (rem >= den)
                begin
                    rem = rem - den;
                    quo = quo | 1;
                end
            end
            cm = quo;
        end
        c = (num < 0) ? -cm : cm;
        s = longint'(int_root(longint'(ONE * ONE - cm * cm)));
        q2 = arc_tangent(s, c);
        n = (lower_link * s) >>> FB;
        d = upper_link + trunc_shift(lower_link * c, FB);
        if (d == 0)
            t = (n != 0) ? q32_to_q(HALF_PI_Q32) : 0;
        else if (d < 0)
            t = arc_tangent(-n, -d);
        else
            t = arc_tangent(n, d);
        q1 = arc_tangent(tip_y, tip_x) - t;
        r.base_drive = ab[15:0];
        r.shoulder_angle = q1[31:0];
        r.elbow_angle = q2[31:0];
        r.move_rejected = rej;
        r.cosine_clamped = clamped;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        int        bad;
        bad = 0;
        if (!rst_n)
        begin
            deadband <= 1638;
            jog_step <= 53687;
            upper_link <= 155692564;
            lower_link <= 155692564;
            tip_x <= longint'(1) << (FB - 1);
            tip_y <= longint'(1) << (FB - 1);
            predicted_joints.delete();
            errors <= 0;
            solved <= 0;
            refused <= 0;
            clamps <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_DEADBAND:   deadband = cfg_data[14:0];
                    CFG_JOG_STEP:   jog_step = cfg_data[19:0];
                    CFG_UPPER_LINK: upper_link = cfg_data;
                    CFG_LOWER_LINK: lower_link = cfg_data;
                    default:        lower_link = lower_link;
                endcase
            end
            if (stick_valid && !stick_stall)
            begin
                want = solve_joints(stick_data);
                predicted_joints.push_back(want);
                solved <= solved + 1;
                if (want.move_rejected) refused <= refused + 1;
                if (want.cosine_clamped) clamps <= clamps + 1;
            end
            if (joint_valid && !joint_stall)
            begin
                if (predicted_joints.size() == 0)
                begin
                    $error("joint transfer with nothing predicted");
                    bad++;
                end
                else
                begin
                    want = predicted_joints.pop_front();
                    if (joint_data.base_drive !== want.base_drive)
                    begin
                        $error("base_drive exp %0d got %0d", want.base_drive,
                               joint_data.base_drive);
                        bad++;
                    end
                    if (joint_data.shoulder_angle !== want.shoulder_angle)
                    begin
                        $error("shoulder_angle exp %0d got %0d", want.shoulder_angle,
                               joint_data.shoulder_angle);
                        bad++;
                    end
                    if (joint_data.elbow_angle !== want.elbow_angle)
                    begin
                        $error("elbow_angle exp %0d got %0d", want.elbow_angle,
                               joint_data.elbow_angle);
                        bad++;
                    end
                    if (joint_data.move_rejected !== want.move_rejected)
                    begin
                        $error("move_rejected exp %0d got %0d", want.move_rejected,
                               joint_data.move_rejected);
                        bad++;
                    end
                    if (joint_data.cosine_clamped !== want.cosine_clamped)
                    begin
                        $error("cosine_clamped exp %0d got %0d", want.cosine_clamped,
                               joint_data.cosine_clamped);
                        bad++;
                    end
                end
            end
            if (bad != 0)
                errors <= errors + bad;
        end
    end

    assign pending = predicted_joints.size();

endmodule

>>> tb/sv/tb.sv
// Testbench top: drives stick transfers and register writes into the arm jog block
module tb;
    import tjik_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        stick_valid;
    logic        stick_stall;
    in_item_t    stick_data;
    logic        joint_valid;
    logic        joint_stall;
    out_item_t   joint_data;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [28:0] cfg_data;
    int          errors;
    int          pending;
    int          solved;
    int          refused;
    int          clamps;
    int          send_idle;
    int          recv_idle;
    int          settings;
    int          run_left;
    int          sign_x;
    int          sign_y;

    two_link_arm_jog_inverse_kinematics i_dut (
        .clk(clk), .rst_n(rst_n),
        .stick_valid(stick_valid), .stick_stall(stick_stall), .stick_data(stick_data),
        .joint_valid(joint_valid), .joint_stall(joint_stall), .joint_data(joint_data),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    tjik_joint_checker i_checker (
        .clk(clk), .rst_n(rst_n),
        .stick_valid(stick_valid), .stick_stall(stick_stall), .stick_data(stick_data),
        .joint_valid(joint_valid), .joint_stall(joint_stall), .joint_data(joint_data),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending), .solved(solved),
        .refused(refused), .clamps(clamps)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

    always @(negedge clk)
        joint_stall <= rst_n && ($urandom_range(99) < recv_idle);

    task automatic set_pressure(int phase);
        case (phase % 4)
            0: begin send_idle = 0;  recv_idle = 0;  end
            1: begin send_idle = 74; recv_idle = 0;  end
            2: begin send_idle = 0;  recv_idle = 74; end
            default: begin send_idle = 24; recv_idle = 24; end
        endcase
    endtask

    task automatic transfer(logic signed [15:0] x, logic signed [15:0] y,
                            logic signed [15:0] b);
        @(negedge clk);
        while ($urandom_range(99) < send_idle)
        begin
            stick_valid = 1'b0;
            @(negedge clk);
        end
        stick_valid = 1'b1;
        stick_data = '{stick_x: x, stick_y: y, stick_base: b};
        do
            @(posedge clk);
        while (stick_stall);
    endtask

    task automatic settle();
        @(negedge clk);
        stick_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [28:0] value);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    task automatic set_links(logic [28:0] upper, logic [28:0] lower);
        write_reg(CFG_UPPER_LINK, upper);
        write_reg(CFG_LOWER_LINK, lower);
        settings++;
    endtask

    function automatic logic signed [15:0] drift_axis(int sgn);
        logic signed [15:0] v;
        v = 16'($urandom_range(32767, 8192));
        return (sgn < 0) ? -v : v;
    endfunction

    task automatic random_run(int count);
        logic signed [15:0] x;
        logic signed [15:0] y;
        for (int k = 0; k < count; k++)
        begin
            if (run_left == 0)
            begin
                run_left = $urandom_range(60, 10);
                sign_x = $urandom_range(2) - 1;
                sign_y = $urandom_range(2) - 1;
            end
            run_left--;
            if ($urandom_range(4) == 0)
            begin
                x = 16'($urandom);
                y = 16'($urandom);
            end
            else
            begin
                x = (sign_x == 0) ? 16'(int'($urandom_range(2000)) - 1000) : drift_axis(sign_x);
                y = (sign_y == 0) ? 16'(int'($urandom_range(2000)) - 1000) : drift_axis(sign_y);
            end
            transfer(x, y, 16'($urandom));
        end
        settle();
    endtask

    initial
    begin
        stick_valid = 1'b0;
        stick_data = '0;
        cfg_write = 1'b0;
        cfg_index = CFG_DEADBAND;
        cfg_data = '0;
        joint_stall = 1'b0;
        send_idle = 0;
        recv_idle = 0;
        settings = 1;
        run_left = 0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // walk the tip from (0.5,0.5) to a 3-4-5 point, then sit exactly on the circle
        set_pressure(0);
        write_reg(CFG_DEADBAND, 29'd0);
        write_reg(CFG_JOG_STEP, 29'd524288);
        repeat (64) transfer(-16'sd32768, 16'sd0, 16'sd5);
        settle();
        set_links(29'd83886080, 29'd83886080);
        set_pressure(3);
        transfer(16'sd0, 16'sd0, -16'sd32768);
        transfer(16'sd32767, 16'sd32767, 16'sd32767);
        transfer(16'sd0, 16'sd1, 16'sd0);
        transfer(16'sd0, -16'sd1, 16'sd0);

        // home the tip to 16 LSB below the origin: elbow folded, atan denominator 1 LSB
        repeat (192) transfer(-16'sd32768, -16'sd32768, 16'sd0);
        repeat (64) transfer(16'sd0, -16'sd32768, 16'sd0);
        transfer(16'sd0, 16'sd0, 16'sd0);
        settle();

        // defaults, deadband edges and field extremes
        set_pressure(2);
        write_reg(CFG_DEADBAND, 29'd1638);
        write_reg(CFG_JOG_STEP, 29'd53687);
        set_links(29'd155692564, 29'd155692564);
        transfer(16'sd1638, -16'sd1638, 16'sd1638);
        transfer(16'sd1639, -16'sd1639, -16'sd1639);
        transfer(16'sd32767, 16'sd32767, 16'sd32767);
        transfer(-16'sd32768, -16'sd32768, -16'sd32768);
        transfer(16'sd0, 16'sd0, 16'sd0);
        transfer(-16'sd1, 16'sd1, -16'sd1);
        random_run(150);

        set_pressure(1);
        write_reg(CFG_DEADBAND, 29'd0);
        write_reg(CFG_JOG_STEP, 29'd1048575);
        settings++;
        random_run(250);

        set_pressure(2);
        set_links(29'd67108864, 29'd67108864);
        random_run(150);

        set_pressure(3);
        write_reg(CFG_DEADBAND, 29'd32767);
        write_reg(CFG_JOG_STEP, 29'd0);
        settings++;
        transfer(-16'sd32768, 16'sd32767, -16'sd32768);
        random_run(100);

        set_pressure(0);
        write_reg(CFG_DEADBAND, 29'd800);
        write_reg(CFG_JOG_STEP, 29'd1048575);
        set_links(29'd1, 29'd536870911);
        random_run(200);

        set_pressure(1);
        set_links(29'd536870911, 29'd1);
        random_run(200);

        set_pressure(2);
        set_links(29'd100000000, 29'd40000000);
        random_run(150);

        $display("Run covered %0d stick transfers under %0d register settings,",
                 solved, settings);
        $display("with %0d moves refused at the reach circle and %0d cosine clamps.",
                 refused, clamps);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
